FILE: sv/tgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_pkg
// Shared types and constants for the scrollback text terminal.
// ----------------------------------------------------------------------------
package tgt_pkg;

    localparam int DEF_COLS          = 44;
    localparam int DEF_ROWS          = 17;
    localparam int DEF_HISTORY_LINES = 48;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int LIVE_W  = CHAR_W + COLOR_W;

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] KEY_PAGE_UP   = 8'h15;
    localparam logic [7:0] KEY_PAGE_DOWN = 8'h16;
    localparam int         PAGE_STEP     = 4;

    typedef enum logic [2:0] {
        REQ_WRITE = 3'd0,
        REQ_CLEAR = 3'd1,
        REQ_COLOR = 3'd2,
        REQ_KEY   = 3'd3,
        REQ_READ  = 3'd4
    } req_code_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] char_code;
        logic [3:0] color_index;
        logic [4:0] view_row;
        logic [5:0] view_col;
    } request_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cell_color;
        logic       scrolled_up;
        logic       changed;
        logic [4:0] cursor_row;
        logic [5:0] cursor_col;
        logic [5:0] view_offset;
        logic [5:0] stored_lines;
    } result_t;

endpackage

FILE: sv/tgt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/text_grid_terminal_scrollback.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_grid_terminal_scrollback
// Character-cell terminal: live grid held as a ring of rows in one RAM,
// scrollback held as a ring of lines in a second RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Word
// request   in         start & !busy         req    (request_t)
// result    out        done, one cycle       result (result_t)
//
// A plain item passes from S_IDLE through S_EXEC and S_RESP; a cell read
// inside the grid adds S_RDWAIT. A write that scrolls walks one row through
// both RAMs in S_SCROLL. A clear walks the whole live RAM in S_CLEAR.
// After reset a clearing pass over all ROWS*COLS cells runs with busy high.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module text_grid_terminal_scrollback
    import tgt_pkg::*;
#(
    parameter int COLS          = DEF_COLS,
    parameter int ROWS          = DEF_ROWS,
    parameter int HISTORY_LINES = DEF_HISTORY_LINES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t req,
    output logic     done,
    output result_t  result
);

    localparam int CW    = $clog2(COLS);
    localparam int SCW   = $clog2(COLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int HW    = $clog2(HISTORY_LINES + 1);
    localparam int HPW   = $clog2(HISTORY_LINES);
    localparam int LDEP  = ROWS * COLS;
    localparam int HDEP  = HISTORY_LINES * COLS;
    localparam int LAW   = $clog2(LDEP);
    localparam int HAW   = $clog2(HDEP);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCROLL,
        S_CLEAR,
        S_RESP
    } state_t;

    state_t             state_reg;
    request_t           req_reg;
    logic [RW-1:0]      cy_reg;
    logic [CW-1:0]      cx_reg;
    logic [HW-1:0]      hc_reg;
    logic [HW-1:0]      vu_reg;
    logic [HPW-1:0]     head_reg;
    logic [RW-1:0]      top_reg;
    logic [3:0]         pen_reg;
    logic [SCW-1:0]     sc_reg;
    logic [LAW-1:0]     ca_reg;
    logic               chg_reg;
    logic               rdh_reg;
    logic [7:0]         cch_reg;
    logic [3:0]         ccol_reg;
    logic               done_reg;
    result_t            result_reg;

    logic               l_we;
    logic [LAW-1:0]     l_waddr;
    logic [LIVE_W-1:0]  l_wdata;
    logic [LAW-1:0]     l_raddr;
    logic [LIVE_W-1:0]  l_rdata;
    logic               h_we;
    logic [HAW-1:0]     h_waddr;
    logic [HAW-1:0]     h_raddr;
    logic [7:0]         h_rdata;

    // Address arithmetic
    logic [RW:0]        pc_sum;
    logic [RW-1:0]      prow_cur;
    logic [RW:0]        top_sum;
    logic [RW-1:0]      top_inc;
    logic [HPW:0]       tail_sum;
    logic [HPW-1:0]     tail;
    logic [HPW:0]       head_sum;
    logic [HPW-1:0]     head_inc;
    logic               in_win;
    logic               rd_hist;
    logic [HW-1:0]      hline;
    logic [HPW:0]       hp_sum;
    logic [HPW-1:0]     hphys;
    logic [RW-1:0]      lrow;
    logic [RW:0]        lr_sum;
    logic [RW-1:0]      prow_rd;
    logic [HW:0]        vu_up;
    logic               hist_full;

    assign pc_sum   = {1'b0, top_reg} + (RW+1)'(cy_reg);
    assign prow_cur = (pc_sum >= (RW+1)'(ROWS)) ? RW'(pc_sum - (RW+1)'(ROWS)) : RW'(pc_sum);
    assign top_sum  = {1'b0, top_reg} + (RW+1)'(1);
    assign top_inc  = (top_sum >= (RW+1)'(ROWS)) ? '0 : RW'(top_sum);
    assign hist_full = (hc_reg >= HW'(HISTORY_LINES));
    assign tail_sum = (HPW+1)'(head_reg) + (HPW+1)'(hc_reg);
    assign tail     = hist_full ? head_reg :
                      ((tail_sum >= (HPW+1)'(HISTORY_LINES)) ?
                       HPW'(tail_sum - (HPW+1)'(HISTORY_LINES)) : HPW'(tail_sum));
    assign head_sum = {1'b0, head_reg} + (HPW+1)'(1);
    assign head_inc = (head_sum >= (HPW+1)'(HISTORY_LINES)) ? '0 : HPW'(head_sum);

    assign in_win  = (32'(req_reg.view_row) < ROWS) && (32'(req_reg.view_col) < COLS);
    assign rd_hist = (32'(req_reg.view_row) < 32'(vu_reg));
    assign hline   = HW'(hc_reg - vu_reg + HW'(req_reg.view_row));
    assign hp_sum  = (HPW+1)'(head_reg) + (HPW+1)'(hline);
    assign hphys   = (hp_sum >= (HPW+1)'(HISTORY_LINES)) ?
                     HPW'(hp_sum - (HPW+1)'(HISTORY_LINES)) : HPW'(hp_sum);
    assign lrow    = RW'(32'(req_reg.view_row) - 32'(vu_reg));
    assign lr_sum  = {1'b0, top_reg} + (RW+1)'(lrow);
    assign prow_rd = (lr_sum >= (RW+1)'(ROWS)) ? RW'(lr_sum - (RW+1)'(ROWS)) : RW'(lr_sum);
    assign vu_up   = (HW+1)'(vu_reg) + (HW+1)'(PAGE_STEP);

    // RAM port steering
    always_comb
    begin
        l_we    = 1'b0;
        l_waddr = LAW'(32'(prow_cur) * COLS + 32'(cx_reg));
        l_wdata = {pen_reg, req_reg.char_code};
        l_raddr = LAW'(32'(prow_rd) * COLS + 32'(req_reg.view_col));
        h_we    = 1'b0;
        h_waddr = HAW'(32'(tail) * COLS + 32'(sc_reg) - 1);
        h_raddr = HAW'(32'(hphys) * COLS + 32'(req_reg.view_col));
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                l_we    = 1'b1;
                l_waddr = ca_reg;
                l_wdata = {4'd0, CHAR_SPACE};
            end
            S_EXEC:
            begin
                l_we = (req_reg.req_type == REQ_WRITE) &&
                       (req_reg.char_code != CHAR_LF) && (req_reg.char_code != CHAR_CR);
            end
            S_SCROLL:
            begin
                l_raddr = LAW'(32'(top_reg) * COLS + 32'(sc_reg));
                l_we    = (sc_reg != '0);
                l_waddr = LAW'(32'(top_reg) * COLS + 32'(sc_reg) - 1);
                l_wdata = {4'd0, CHAR_SPACE};
                h_we    = (sc_reg != '0);
            end
            default:
            begin
            end
        endcase
    end

    tgt_ram #(.WIDTH(LIVE_W), .DEPTH(LDEP)) u_live (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    tgt_ram #(.WIDTH(CHAR_W), .DEPTH(HDEP)) u_hist (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (l_rdata[7:0]),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            req_reg   <= '0;
            cy_reg    <= '0;
            cx_reg    <= '0;
            hc_reg    <= '0;
            vu_reg    <= '0;
            head_reg  <= '0;
            top_reg   <= '0;
            pen_reg   <= '0;
            sc_reg    <= '0;
            ca_reg    <= '0;
            chg_reg   <= 1'b0;
            rdh_reg   <= 1'b0;
            cch_reg   <= '0;
            ccol_reg  <= '0;
            done_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    if (32'(ca_reg) == LDEP - 1)
                    begin
                        ca_reg    <= '0;
                        state_reg <= (state_reg == S_INIT) ? S_IDLE : S_RESP;
                    end
                    else
                    begin
                        ca_reg <= ca_reg + LAW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    chg_reg   <= 1'b0;
                    cch_reg   <= '0;
                    ccol_reg  <= '0;
                    state_reg <= S_RESP;
                    unique case (req_reg.req_type)
                        REQ_WRITE:
                        begin
                            chg_reg <= 1'b1;
                            if (req_reg.char_code == CHAR_CR)
                            begin
                                cx_reg <= '0;
                            end
                            else if ((req_reg.char_code == CHAR_LF) ||
                                     (32'(cx_reg) == COLS - 1))
                            begin
                                cx_reg <= '0;
                                if (32'(cy_reg) == ROWS - 1)
                                begin
                                    sc_reg    <= '0;
                                    state_reg <= S_SCROLL;
                                end
                                else
                                begin
                                    cy_reg <= cy_reg + RW'(1);
                                end
                            end
                            else
                            begin
                                cx_reg <= cx_reg + CW'(1);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            chg_reg   <= 1'b1;
                            cx_reg    <= '0;
                            cy_reg    <= '0;
                            hc_reg    <= '0;
                            vu_reg    <= '0;
                            head_reg  <= '0;
                            top_reg   <= '0;
                            ca_reg    <= '0;
                            state_reg <= S_CLEAR;
                        end
                        REQ_COLOR:
                        begin
                            pen_reg <= req_reg.color_index;
                        end
                        REQ_KEY:
                        begin
                            priority if (req_reg.char_code == KEY_PAGE_UP)
                            begin
                                if (vu_reg < hc_reg)
                                begin
                                    chg_reg <= 1'b1;
                                    vu_reg  <= (vu_up > (HW+1)'(hc_reg)) ? hc_reg : HW'(vu_up);
                                end
                            end
                            else if (req_reg.char_code == KEY_PAGE_DOWN)
                            begin
                                if (vu_reg != '0)
                                begin
                                    chg_reg <= 1'b1;
                                    vu_reg  <= (vu_reg > HW'(PAGE_STEP)) ?
                                               vu_reg - HW'(PAGE_STEP) : '0;
                                end
                            end
                            else
                            begin
                                if (vu_reg != '0)
                                begin
                                    chg_reg <= 1'b1;
                                    vu_reg  <= '0;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            cch_reg <= CHAR_SPACE;
                            if (in_win)
                            begin
                                rdh_reg   <= rd_hist;
                                state_reg <= S_RDWAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_RDWAIT:
                begin
                    if (rdh_reg)
                    begin
                        cch_reg  <= h_rdata;
                        ccol_reg <= '0;
                    end
                    else
                    begin
                        cch_reg  <= l_rdata[7:0];
                        ccol_reg <= l_rdata[11:8];
                    end
                    state_reg <= S_RESP;
                end
                S_SCROLL:
                begin
                    if (32'(sc_reg) == COLS)
                    begin
                        top_reg <= top_inc;
                        cy_reg  <= RW'(ROWS - 1);
                        if (hist_full)
                        begin
                            head_reg <= head_inc;
                        end
                        else
                        begin
                            hc_reg <= hc_reg + HW'(1);
                            if (vu_reg != '0)
                            begin
                                vu_reg <= vu_reg + HW'(1);
                            end
                        end
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        sc_reg <= sc_reg + SCW'(1);
                    end
                end
                S_RESP:
                begin
                    result_reg.cell_char    <= cch_reg;
                    result_reg.cell_color   <= ccol_reg;
                    result_reg.scrolled_up  <= (vu_reg != '0);
                    result_reg.changed      <= chg_reg;
                    result_reg.cursor_row   <= 5'(cy_reg);
                    result_reg.cursor_col   <= 6'(cx_reg);
                    result_reg.view_offset  <= 6'(vu_reg);
                    result_reg.stored_lines <= 6'(hc_reg);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_view_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vu_reg <= hc_reg)
        else $error("view raised above stored lines");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cy_reg) < ROWS) && (32'(cx_reg) < COLS))
        else $error("cursor outside grid");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

endmodule
